// File: sv/utf8v_pkg.sv
// Package for the UTF-8 name validator: request item type and register map.
// No dependencies; the top level and utf8v_step take names from here by scope.
`timescale 1ns / 1ps

package utf8v_pkg;

	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int MAX_CP_BITS = 10;

	// Register map: word index of each register
	localparam logic [APB_ADDR_W-3:0] REG_MAX_CODE_POINTS = '0;

	localparam logic [MAX_CP_BITS-1:0] MAX_CP_RESET = 10'd64;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       empty_string;
	} item_t;

endpackage

// File: sv/utf8v_in_if.sv
// Input channel of the UTF-8 name validator: one string byte per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface utf8v_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	logic       empty_string;

	modport source (output valid, data_byte, last, empty_string, input ready);
	modport sink (input valid, data_byte, last, empty_string, output ready);
endinterface

// File: sv/utf8v_out_if.sv
// Result channel of the UTF-8 name validator: verdict and code point count.
// Depends on nothing; COUNT_BITS sets the count width.
`timescale 1ns / 1ps

interface utf8v_out_if #(
	parameter int COUNT_BITS = 11
);
	logic                  valid;
	logic                  ready;
	logic                  valid_res;
	logic [COUNT_BITS-1:0] code_points;

	modport source (output valid, valid_res, code_points, input ready);
	modport sink (input valid, valid_res, code_points, output ready);
endinterface

// File: sv/utf8_name_validator.sv
// UTF-8 name validator top level: request register, step logic, result register
// and the APB register. Depends on utf8v_pkg, utf8v_in_if, utf8v_out_if, utf8v_step.
`timescale 1ns / 1ps

// Usage
// A string enters on in_ch one byte per request; last marks its final byte and
// empty_string closes a string of zero bytes (data_byte is then ignored). Each
// closing request yields one result on out_ch: valid_res is 1 when the string is
// well-formed UTF-8, free of C0/C1 controls and holds 1 to max_code_points code
// points; code_points is the count, saturating at max_code_points + 1.
// A closing request passes from the request register into the result register.
// Throughput: one byte per cycle, bar the stall below; the per-byte decoder
// state feeds back through a single register stage, which sets the rate.
// A stalled out_ch holds its result; the request register behind it keeps
// taking bytes that produce no result and only blocks on the next closing byte.
// Reset (arst_n low) clears all string state, empties both registers and sets
// max_code_points to 64. Write max_code_points at byte address 0 over APB while
// no string is in flight; reads return the register, pready is always high.

module utf8_name_validator #(
	parameter int COUNT_BITS = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [utf8v_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [utf8v_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [utf8v_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	utf8v_in_if.sink                            in_ch,
	utf8v_out_if.source                         out_ch
);

	logic [utf8v_pkg::MAX_CP_BITS-1:0] max_cp_q;
	logic                              reg_hit;

	logic                  valid_s1;
	utf8v_pkg::item_t      item_s1;
	logic                  in_accept;
	logic                  advance;
	logic                  out_free;

	logic                  has_res;
	logic                  res_ok;
	logic [COUNT_BITS-1:0] res_count;

	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [COUNT_BITS-1:0] out_count_q;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_hit = (paddr[utf8v_pkg::APB_ADDR_W-1:2] == utf8v_pkg::REG_MAX_CODE_POINTS);
	assign prdata  = reg_hit ?
		{{(utf8v_pkg::APB_DATA_W-utf8v_pkg::MAX_CP_BITS){1'b0}}, max_cp_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_cp_q <= utf8v_pkg::MAX_CP_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_cp_q <= pwdata[utf8v_pkg::MAX_CP_BITS-1:0];
		end
	end

	// Handshake: stall only when a result must wait for a full output register
	assign out_free    = !out_valid_q || out_ch.ready;
	assign advance     = valid_s1 && (!has_res || out_free);
	assign in_ch.ready = !valid_s1 || advance;
	assign in_accept   = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.data_byte    <= in_ch.data_byte;
			item_s1.last         <= in_ch.last;
			item_s1.empty_string <= in_ch.empty_string;
		end
	end

	utf8v_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item            (item_s1),
		.max_code_points (max_cp_q),
		.has_res         (has_res),
		.res_ok          (res_ok),
		.res_count       (res_count)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_ok_q    <= res_ok;
			out_count_q <= res_count;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.valid_res   = out_ok_q;
	assign out_ch.code_points = out_count_q;

endmodule

// File: sv/utf8v_step.sv
// Per-string decoder state and the combinational UTF-8 step logic.
// Depends on utf8v_pkg (item_t, MAX_CP_BITS).
`timescale 1ns / 1ps

module utf8v_step #(
	parameter int COUNT_BITS = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  utf8v_pkg::item_t                    item,
	input  logic [utf8v_pkg::MAX_CP_BITS-1:0]   max_code_points,
	output logic                                has_res,
	output logic                                res_ok,
	output logic [COUNT_BITS-1:0]               res_count
);

	localparam int CMP_W = ((COUNT_BITS > utf8v_pkg::MAX_CP_BITS) ?
		COUNT_BITS : utf8v_pkg::MAX_CP_BITS) + 1;

	localparam logic [7:0]  ASCII_MAX  = 8'h7f;
	localparam logic [7:0]  LEAD2_MIN  = 8'hc2;
	localparam logic [7:0]  LEAD2_MAX  = 8'hdf;
	localparam logic [7:0]  LEAD3_MIN  = 8'he0;
	localparam logic [7:0]  LEAD3_MAX  = 8'hef;
	localparam logic [7:0]  LEAD4_MIN  = 8'hf0;
	localparam logic [7:0]  LEAD4_MAX  = 8'hf4;
	localparam logic [20:0] CP_MAX     = 21'h10ffff;
	localparam logic [20:0] SURR_MIN   = 21'h00d800;
	localparam logic [20:0] SURR_MAX   = 21'h00dfff;
	localparam logic [20:0] MIN3       = 21'h000800;
	localparam logic [20:0] MIN4       = 21'h010000;
	localparam logic [20:0] C0_MAX     = 21'h00001f;
	localparam logic [20:0] C1_MIN     = 21'h00007f;
	localparam logic [20:0] C1_MAX     = 21'h00009f;

	logic [1:0]            bytes_left_q, bytes_left_d;
	logic [2:0]            seq_width_q, seq_width_d;
	logic [20:0]           partial_q, partial_d;
	logic [COUNT_BITS-1:0] count_q, count_d;
	logic                  failed_q, failed_d;

	logic                  fin;
	logic [20:0]           cp;
	logic                  bad_cp;
	logic [CMP_W-1:0]      max_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic [CMP_W-1:0]      cnt_new_ext;
	logic [COUNT_BITS-1:0] cnt_new;
	logic                  fail_end;
	logic [7:0]            b;

	assign b       = item.data_byte;
	assign max_ext = {{(CMP_W-utf8v_pkg::MAX_CP_BITS){1'b0}}, max_code_points};
	assign cnt_ext = {{(CMP_W-COUNT_BITS){1'b0}}, count_q};

	always_comb begin
		bytes_left_d = bytes_left_q;
		seq_width_d  = seq_width_q;
		partial_d    = partial_q;
		count_d      = count_q;
		failed_d     = failed_q;
		fin          = 1'b0;
		cp           = partial_q;
		bad_cp       = 1'b0;
		cnt_new      = count_q;
		cnt_new_ext  = cnt_ext;
		has_res      = 1'b0;
		res_ok       = 1'b0;
		res_count    = '0;
		fail_end     = 1'b0;

		if (!failed_q) begin
			if (bytes_left_q == 2'd0) begin
				priority if (b <= ASCII_MAX) begin
					cp          = {13'd0, b};
					partial_d   = cp;
					seq_width_d = 3'd1;
					fin         = 1'b1;
				end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					partial_d    = {16'd0, b[4:0]};
					seq_width_d  = 3'd2;
					bytes_left_d = 2'd1;
				end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
					partial_d    = {17'd0, b[3:0]};
					seq_width_d  = 3'd3;
					bytes_left_d = 2'd2;
				end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
					partial_d    = {18'd0, b[2:0]};
					seq_width_d  = 3'd4;
					bytes_left_d = 2'd3;
				end else begin
					failed_d = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				failed_d = 1'b1;
			end else begin
				cp           = {partial_q[14:0], b[5:0]};
				partial_d    = cp;
				bytes_left_d = bytes_left_q - 2'd1;
				fin          = (bytes_left_q == 2'd1);
			end
		end

		// Range checks on a completed code point, then count it
		if (fin) begin
			bad_cp = (seq_width_d == 3'd3 && cp < MIN3) ||
				(seq_width_d == 3'd3 && cp >= SURR_MIN && cp <= SURR_MAX) ||
				(seq_width_d == 3'd4 && cp < MIN4) || (cp > CP_MAX) ||
				(cp <= C0_MAX) || (cp >= C1_MIN && cp <= C1_MAX);
			if (bad_cp) begin
				failed_d = 1'b1;
			end else begin
				if (count_q != '1 && cnt_ext <= max_ext) begin
					cnt_new = count_q + 1'b1;
				end
				cnt_new_ext = {{(CMP_W-COUNT_BITS){1'b0}}, cnt_new};
				count_d     = cnt_new;
				if (cnt_new_ext > max_ext) begin
					failed_d = 1'b1;
				end
			end
		end

		priority if (item.empty_string) begin
			has_res = 1'b1;
		end else if (item.last) begin
			has_res   = 1'b1;
			fail_end  = failed_d || (bytes_left_d != 2'd0);
			res_ok    = !fail_end && (count_d != '0);
			res_count = count_d;
		end else begin
			has_res = 1'b0;
		end

		// Close the string: drop all per-string state
		if (has_res) begin
			bytes_left_d = 2'd0;
			seq_width_d  = 3'd0;
			partial_d    = '0;
			count_d      = '0;
			failed_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			seq_width_q  <= 3'd0;
			partial_q    <= '0;
			count_q      <= '0;
			failed_q     <= 1'b0;
		end else if (advance) begin
			bytes_left_q <= bytes_left_d;
			seq_width_q  <= seq_width_d;
			partial_q    <= partial_d;
			count_q      <= count_d;
			failed_q     <= failed_d;
		end
	end

endmodule

// File: sv/utf8v_checker.sv
// Port-level checks for the UTF-8 name validator, bound to the top level.
// Depends on utf8_name_validator and its interface ports.
`timescale 1ns / 1ps

module utf8v_checker #(
	parameter int COUNT_BITS = 11
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  out_valid_res,
	input logic [COUNT_BITS-1:0] out_code_points
);

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_valid_res) &&
			$stable(out_code_points))
	else $error("result changed while stalled");

	// A passing string has at least one code point
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_valid_res |-> out_code_points != '0)
	else $error("valid verdict with zero code points");

	// Input backpressure only comes from a stalled, full result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("input stalled without output stall");

endmodule

bind utf8_name_validator utf8v_checker #(
	.COUNT_BITS(COUNT_BITS)
) u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.out_valid_res   (out_ch.valid_res),
	.out_code_points (out_ch.code_points)
);
